/* src/mmir_pkg.sv */
// Package for the modal menu input router: shared types, action and direction
// codes, register map and sizing constants.
// No dependencies; every other file of the block imports it.
package mmir_pkg;

   // Most actions that one frame may produce, and the width of a count up to it.
   localparam int MAX_ACTIONS_BOUND = 16;
   localparam int CAP_W = ($clog2(MAX_ACTIONS_BOUND + 1) > 5) ?
                          $clog2(MAX_ACTIONS_BOUND + 1) : 5;

   // Queue between the front and the back; depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Stream and register port widths.
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // Repeat countdown: signed milliseconds, saturating at its most negative value.
   localparam int CD_W = 20;
   localparam logic [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};

   // Held direction codes.
   localparam logic [2:0] DIR_UP    = 3'd0;
   localparam logic [2:0] DIR_DOWN  = 3'd1;
   localparam logic [2:0] DIR_LEFT  = 3'd2;
   localparam logic [2:0] DIR_RIGHT = 3'd3;
   localparam logic [2:0] DIR_NONE  = 3'd4;

   // Menu action codes.
   localparam logic [3:0] ACT_START     = 4'd6;
   localparam logic [3:0] ACT_ACCEPT    = 4'd4;
   localparam logic [3:0] ACT_CANCEL    = 4'd5;
   localparam logic [3:0] ACT_PREV_TAB  = 4'd7;
   localparam logic [3:0] ACT_NEXT_TAB  = 4'd8;
   localparam logic [3:0] ACT_SECONDARY = 4'd9;
   localparam logic [3:0] ACT_TERTIARY  = 4'd10;
   localparam logic [3:0] ACT_PREV_PAGE = 4'd11;
   localparam logic [3:0] ACT_NEXT_PAGE = 4'd12;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_ENGAGE      = 3'd0;
   localparam logic [2:0] REG_RELEASE     = 3'd1;
   localparam logic [2:0] REG_FIRST_DELAY = 3'd2;
   localparam logic [2:0] REG_PERIOD      = 3'd3;
   localparam logic [2:0] REG_BLOCK       = 3'd4;
   localparam logic [2:0] REG_MAX_ACTIONS = 3'd5;

   // Register reset values.
   localparam logic [14:0] ENGAGE_RESET      = 15'd16384;
   localparam logic [14:0] RELEASE_RESET     = 15'd9830;
   localparam logic [15:0] FIRST_DELAY_RESET = 16'd400;
   localparam logic [15:0] PERIOD_RESET      = 16'd120;
   localparam logic [14:0] BLOCK_RESET       = 15'd11469;
   localparam logic [4:0]  MAX_ACTIONS_RESET = 5'd16;

   typedef struct packed {
      logic [14:0] engage_level;
      logic [14:0] release_level;
      logic [15:0] first_repeat_delay;
      logic [15:0] repeat_period;
      logic [14:0] block_level;
      logic [4:0]  max_actions;
   } cfg_type;

   // One action word as it travels through the queue.
   typedef struct packed {
      logic       last;
      logic [3:0] action;
   } item_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_EVAL,
      FR_EMIT
   } fr_state_type;

endpackage

/* src/modal_menu_input_router.sv */
// Top level of the modal menu input router: configuration registers, front,
// action queue and back. Depends on mmir_pkg, mmir_front, mmir_queue, mmir_back.
// Sequence per frame: take the word, evaluate it, produce its actions one at a time, then push
// the held final action, if any; no new frame word is taken until the frame is closed.
// The back drains one action a cycle from a four-word queue while rsp_tready is high;
// only back-pressure stalls the front.
// Reset: synchronous; registers return to their defaults and all navigator state clears.
module modal_menu_input_router import mmir_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // stick_x, stick_y, buttons, elapsed_ms
   input  logic                   req_tuser,  // modal_active
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // action
   output logic                   rsp_tlast,  // last_action
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [2:0] reg_idx;
   logic       q_push, q_full, q_pop, q_empty;
   item_type   q_in_item, q_out_item;

   // Register writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_ENGAGE:      cfg_in.engage_level       = csr_pwdata[14:0];
            REG_RELEASE:     cfg_in.release_level      = csr_pwdata[14:0];
            REG_FIRST_DELAY: cfg_in.first_repeat_delay = csr_pwdata[15:0];
            REG_PERIOD:      cfg_in.repeat_period      = csr_pwdata[15:0];
            REG_BLOCK:       cfg_in.block_level        = csr_pwdata[14:0];
            REG_MAX_ACTIONS: cfg_in.max_actions        = csr_pwdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back of the selected register.
   always_comb begin
      case (reg_idx)
         REG_ENGAGE:      csr_prdata = {17'd0, cfg_ff.engage_level};
         REG_RELEASE:     csr_prdata = {17'd0, cfg_ff.release_level};
         REG_FIRST_DELAY: csr_prdata = {16'd0, cfg_ff.first_repeat_delay};
         REG_PERIOD:      csr_prdata = {16'd0, cfg_ff.repeat_period};
         REG_BLOCK:       csr_prdata = {17'd0, cfg_ff.block_level};
         REG_MAX_ACTIONS: csr_prdata = {27'd0, cfg_ff.max_actions};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.engage_level       <= ENGAGE_RESET;
         cfg_ff.release_level      <= RELEASE_RESET;
         cfg_ff.first_repeat_delay <= FIRST_DELAY_RESET;
         cfg_ff.repeat_period      <= PERIOD_RESET;
         cfg_ff.block_level        <= BLOCK_RESET;
         cfg_ff.max_actions        <= MAX_ACTIONS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Frame evaluation and action generation.
   mmir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_push     (q_push),
      .q_item     (q_in_item),
      .q_full     (q_full)
   );

   // Queue between the two halves.
   mmir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   // Result stream output register.
   mmir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_out_item),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/mmir_queue.sv */
// Short first-in first-out queue of action words between the front and the back.
// Depends on mmir_pkg for the word type and the depth.
module mmir_queue import mmir_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    fill_ff, fill_in;
   logic               do_push, do_pop;

   // Occupancy flags and the word at the head.
   assign full     = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/mmir_front.sv */
// Front of the router: takes a controller frame, updates the navigator and
// button state, then produces the frame's actions one per cycle into the queue while it has room.
// Depends on mmir_pkg.
module mmir_front import mmir_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  cfg_type                cfg,
   output logic                   q_push,
   output item_type               q_item,
   input  logic                   q_full
);

   function automatic logic [15:0] mag16(input logic [15:0] v);
      mag16 = v[15] ? (~v + 16'd1) : v;
   endfunction

   function automatic logic is_pos(input logic [15:0] v);
      is_pos = (v != 16'd0) && !v[15];
   endfunction

   // Action code for each bit of the pending mask, lowest bit first.
   function automatic logic [3:0] post_code(input logic [2:0] idx);
      logic [3:0] code;
      case (idx)
         3'd0:    code = ACT_ACCEPT;
         3'd1:    code = ACT_CANCEL;
         3'd2:    code = ACT_PREV_TAB;
         3'd3:    code = ACT_NEXT_TAB;
         3'd4:    code = ACT_SECONDARY;
         3'd5:    code = ACT_TERTIARY;
         3'd6:    code = ACT_PREV_PAGE;
         default: code = ACT_NEXT_PAGE;
      endcase
      return code;
   endfunction

   fr_state_type      fr_state_ff, fr_state_in;

   // Frame held for evaluation.
   logic [15:0]       sx_ff, sy_ff, ms_ff;
   logic [8:0]        btn_ff;
   logic              modal_ff;

   // Navigator and button state.
   logic [2:0]        held_ff, held_in;
   logic [CD_W-1:0]   cd_ff, cd_in;
   logic              acc_prev_ff, acc_prev_in, can_prev_ff, can_prev_in;
   logic              start_prev_ff, start_prev_in, modal_prev_ff, modal_prev_in;
   logic              stick_blk_ff, stick_blk_in;
   logic [7:0]        btn_blk_ff, btn_blk_in;
   logic [5:0]        extra_prev_ff, extra_prev_in;
   logic [1:0]        tab_pend_ff, tab_pend_in;
   logic              chord_ff, chord_in;

   // Emission plan for the current frame.
   logic [CAP_W-1:0]  cap_ff, cap_in, count_ff, count_in;
   logic              start_pend_ff, start_pend_in;
   logic              dir_pend_ff, dir_pend_in;
   logic              rep_mode_ff, rep_mode_in;
   logic [7:0]        post_ff, post_in;
   logic              hold_valid_ff, hold_valid_in;
   logic [3:0]        hold_act_ff, hold_act_in;

   // Frame classification.
   logic [CAP_W-1:0]  cap;
   logic              fire_start, over, rst_nav, nav_called, changed, chord_press;
   logic [7:0]        bl8, btn_blk0, btn_blk1, down_all;
   logic [2:0]        held0, now_dir;
   logic [CD_W-1:0]   cd0, c_sat;
   logic [CD_W:0]     c_sub;
   logic              acc_prev0, can_prev0, stick_blk0, stick_blk1, chord0, chord1;
   logic [5:0]        extra_prev0;
   logic [1:0]        tab_pend0, tab_pend1, tab_pend2, fire_tab;
   logic [15:0]       x_eff, y_eff, ax, ay;
   logic [14:0]       th;
   logic              rep_pend, pend_any, room, can_go;
   logic [2:0]        post_idx;

   // Capacity of this frame, clamped to the bound.
   assign cap = (CAP_W'(cfg.max_actions) > CAP_W'(MAX_ACTIONS_BOUND)) ?
                CAP_W'(MAX_ACTIONS_BOUND) : CAP_W'(cfg.max_actions);

   // Edges, blocking and the navigator reset on modal entry and while no modal is active.
   assign fire_start = btn_ff[2] && !start_prev_ff;
   assign bl8        = {btn_ff[8:3], btn_ff[1:0]};
   assign over       = (mag16(sx_ff) > {1'b0, cfg.block_level}) ||
                       (mag16(sy_ff) > {1'b0, cfg.block_level});
   assign rst_nav    = !modal_ff || !modal_prev_ff;

   assign held0       = rst_nav ? DIR_NONE : held_ff;
   assign cd0         = rst_nav ? '0 : cd_ff;
   assign acc_prev0   = rst_nav ? 1'b0 : acc_prev_ff;
   assign can_prev0   = rst_nav ? 1'b0 : can_prev_ff;
   assign stick_blk0  = rst_nav ? over : stick_blk_ff;
   assign btn_blk0    = rst_nav ? bl8 : btn_blk_ff;
   assign extra_prev0 = rst_nav ? 6'd0 : extra_prev_ff;
   assign tab_pend0   = rst_nav ? 2'd0 : tab_pend_ff;
   assign chord0      = rst_nav ? 1'b0 : chord_ff;

   assign stick_blk1 = modal_ff ? (stick_blk0 && over) : stick_blk0;
   assign btn_blk1   = modal_ff ? (btn_blk0 & bl8) : btn_blk0;
   assign down_all   = bl8 & ~btn_blk1;

   // The navigator runs only if the start action left room in the list.
   assign nav_called = modal_ff && !(fire_start && (cap == CAP_W'(1)));

   // Dominant axis with hysteresis; a blocked stick reads as centred.
   assign x_eff   = stick_blk1 ? 16'd0 : sx_ff;
   assign y_eff   = stick_blk1 ? 16'd0 : sy_ff;
   assign ax      = mag16(x_eff);
   assign ay      = mag16(y_eff);
   assign th      = (held0 == DIR_NONE) ? cfg.engage_level : cfg.release_level;
   always_comb begin
      if ((ax < {1'b0, th}) && (ay < {1'b0, th})) begin
         now_dir = DIR_NONE;
      end else if (ax >= ay) begin
         now_dir = is_pos(x_eff) ? DIR_RIGHT : DIR_LEFT;
      end else begin
         now_dir = is_pos(y_eff) ? DIR_UP : DIR_DOWN;
      end
   end
   assign changed = (now_dir != held0);

   // Countdown after this frame's time, held at its floor.
   assign c_sub = {cd0[CD_W-1], cd0} - {{(CD_W-15){1'b0}}, ms_ff};
   assign c_sat = ($signed(c_sub) < $signed({1'b1, CD_MIN})) ? CD_MIN : c_sub[CD_W-1:0];

   // Tab buttons fire on release; pressing both at once cancels both.
   assign chord_press = btn_ff[3] && btn_ff[4];
   assign chord1      = chord0 || chord_press;
   assign tab_pend1   = chord_press ? 2'd0 : tab_pend0;
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         fire_tab[i]  = !down_all[i+2] && tab_pend1[i] && !chord1;
         tab_pend2[i] = down_all[i+2] && (tab_pend1[i] || (!extra_prev0[i] && !chord1));
      end
   end

   // Emission bookkeeping.
   assign rep_pend = rep_mode_ff && (cd_ff[CD_W-1] || (cd_ff == '0));
   assign pend_any = start_pend_ff || dir_pend_ff || rep_pend || (post_ff != 8'd0);
   assign room     = (count_ff != cap_ff);
   assign can_go   = !hold_valid_ff || !q_full;

   // Lowest pending bit of the fixed actions.
   always_comb begin
      post_idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (post_ff[i]) begin
            post_idx = 3'(i);
         end
      end
   end

   // Sequencer: next state and the word handed to the queue.
   always_comb begin
      fr_state_in   = fr_state_ff;
      held_in       = held_ff;
      cd_in         = cd_ff;
      acc_prev_in   = acc_prev_ff;
      can_prev_in   = can_prev_ff;
      start_prev_in = start_prev_ff;
      modal_prev_in = modal_prev_ff;
      stick_blk_in  = stick_blk_ff;
      btn_blk_in    = btn_blk_ff;
      extra_prev_in = extra_prev_ff;
      tab_pend_in   = tab_pend_ff;
      chord_in      = chord_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      start_pend_in = start_pend_ff;
      dir_pend_in   = dir_pend_ff;
      rep_mode_in   = rep_mode_ff;
      post_in       = post_ff;
      hold_valid_in = hold_valid_ff;
      hold_act_in   = hold_act_ff;
      req_tready    = 1'b0;
      q_push        = 1'b0;
      q_item.last   = 1'b0;
      q_item.action = hold_act_ff;
      case (fr_state_ff)
         FR_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               fr_state_in = FR_EVAL;
            end
         end
         FR_EVAL: begin
            fr_state_in   = FR_EMIT;
            cap_in        = cap;
            count_in      = '0;
            start_pend_in = 1'b0;
            dir_pend_in   = 1'b0;
            rep_mode_in   = 1'b0;
            post_in       = 8'd0;
            // A frame with no capacity leaves the navigator and button state alone.
            if (cap != '0) begin
               start_pend_in = fire_start;
               start_prev_in = btn_ff[2];
               modal_prev_in = modal_ff;
               stick_blk_in  = stick_blk1;
               btn_blk_in    = btn_blk1;
               held_in       = held0;
               cd_in         = cd0;
               acc_prev_in   = acc_prev0;
               can_prev_in   = can_prev0;
               extra_prev_in = extra_prev0;
               tab_pend_in   = tab_pend0;
               chord_in      = chord0;
               if (nav_called) begin
                  if (changed) begin
                     held_in     = now_dir;
                     cd_in       = {{(CD_W-16){1'b0}}, cfg.first_repeat_delay};
                     dir_pend_in = (now_dir != DIR_NONE);
                  end else if (held0 != DIR_NONE) begin
                     cd_in       = c_sat;
                     rep_mode_in = 1'b1;
                  end
                  acc_prev_in = down_all[0];
                  can_prev_in = down_all[1];
                  post_in[0]  = down_all[0] && !acc_prev0;
                  post_in[1]  = down_all[1] && !can_prev0;
               end
               if (modal_ff) begin
                  post_in[3:2]  = fire_tab;
                  post_in[7:4]  = down_all[7:4] & ~extra_prev0[5:2];
                  extra_prev_in = down_all[7:2];
                  tab_pend_in   = tab_pend2;
                  chord_in      = chord1 && (btn_ff[3] || btn_ff[4]);
               end
            end
         end
         FR_EMIT: begin
            if (room && pend_any) begin
               // Each new action pushes the one before it, which is then not last.
               if (can_go) begin
                  q_push        = hold_valid_ff;
                  hold_valid_in = 1'b1;
                  count_in      = count_ff + 1'b1;
                  if (start_pend_ff) begin
                     hold_act_in   = ACT_START;
                     start_pend_in = 1'b0;
                  end else if (dir_pend_ff) begin
                     hold_act_in = {1'b0, held_ff};
                     dir_pend_in = 1'b0;
                  end else if (rep_pend) begin
                     hold_act_in = {1'b0, held_ff};
                     cd_in       = cd_ff + {{(CD_W-16){1'b0}}, cfg.repeat_period};
                  end else begin
                     hold_act_in = post_code(post_idx);
                     post_in     = post_ff & (post_ff - 8'd1);
                  end
               end
            end else if (!hold_valid_ff) begin
               fr_state_in = FR_IDLE;
            end else if (!q_full) begin
               // The word still held is the frame's final action.
               q_push        = 1'b1;
               q_item.last   = 1'b1;
               hold_valid_in = 1'b0;
               fr_state_in   = FR_IDLE;
            end
         end
         default: begin
            fr_state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_state_ff   <= FR_IDLE;
         held_ff       <= DIR_NONE;
         cd_ff         <= '0;
         acc_prev_ff   <= 1'b0;
         can_prev_ff   <= 1'b0;
         start_prev_ff <= 1'b0;
         modal_prev_ff <= 1'b0;
         stick_blk_ff  <= 1'b0;
         btn_blk_ff    <= 8'd0;
         extra_prev_ff <= 6'd0;
         tab_pend_ff   <= 2'd0;
         chord_ff      <= 1'b0;
         cap_ff        <= '0;
         count_ff      <= '0;
         start_pend_ff <= 1'b0;
         dir_pend_ff   <= 1'b0;
         rep_mode_ff   <= 1'b0;
         post_ff       <= 8'd0;
         hold_valid_ff <= 1'b0;
      end else begin
         fr_state_ff   <= fr_state_in;
         held_ff       <= held_in;
         cd_ff         <= cd_in;
         acc_prev_ff   <= acc_prev_in;
         can_prev_ff   <= can_prev_in;
         start_prev_ff <= start_prev_in;
         modal_prev_ff <= modal_prev_in;
         stick_blk_ff  <= stick_blk_in;
         btn_blk_ff    <= btn_blk_in;
         extra_prev_ff <= extra_prev_in;
         tab_pend_ff   <= tab_pend_in;
         chord_ff      <= chord_in;
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         start_pend_ff <= start_pend_in;
         dir_pend_ff   <= dir_pend_in;
         rep_mode_ff   <= rep_mode_in;
         post_ff       <= post_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Frame capture and the held action word carry no reset.
   always_ff @(posedge clock) begin
      hold_act_ff <= hold_act_in;
      if (req_tvalid && req_tready) begin
         sx_ff    <= req_tdata[15:0];
         sy_ff    <= req_tdata[31:16];
         btn_ff   <= req_tdata[40:32];
         ms_ff    <= req_tdata[56:41];
         modal_ff <= req_tuser;
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front pushed a word into a full queue");

   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      (fr_state_ff == FR_EMIT) |-> (count_ff <= cap_ff))
      else $error("more actions produced than the frame may hold");

   a_last_closes_frame: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_item.last) |=> ((fr_state_ff == FR_IDLE) && !hold_valid_ff))
      else $error("frame did not close after its final action");

   a_accept_starts_clean: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ((fr_state_ff == FR_EVAL) && !hold_valid_ff))
      else $error("frame accepted while an action was still held");

endmodule

/* src/mmir_back.sv */
// Back of the router: takes action words from the queue and presents them on
// the result stream through an output register. Depends on mmir_pkg.
module mmir_back import mmir_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  item_type               q_item,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Load a new word whenever the register is empty or being drained.
   assign q_pop    = !q_empty && (!valid_ff || rsp_tready);
   assign valid_in = q_pop ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-4){1'b0}}, item_ff.action};
   assign rsp_tlast  = item_ff.last;

endmodule
